@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/mcpf_pkg.sv @@
package mcpf_pkg;

	localparam int NUM_CHANNELS_DEF = 42;
	localparam int PWM_TOP          = 10;
	localparam int CH_W             = 6;
	localparam int LVL_W            = 4;
	localparam int LED_W            = 42;
	localparam int RAMP_W           = 16;
	localparam int ADDR_W           = 3;
	localparam int DATA_W           = 32;

	localparam logic [RAMP_W-1:0] RAMP_RESET = 16'd25;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_RAMP = 1'b0;

	typedef struct packed {
		logic              cmd;
		logic [CH_W-1:0]   channel;
		logic [LVL_W-1:0]  level;
		logic              immediate;
		logic [LVL_W-1:0]  phase;
		logic              ramp;
	} item_t;

endpackage

@@ src/mcpf_if.sv @@
interface mcpf_req_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [mcpf_pkg::CH_W-1:0]   channel;
	logic [mcpf_pkg::LVL_W-1:0]  level;
	logic                        immediate;

	modport source (output valid, cmd, channel, level, immediate, input ready);
	modport sink (input valid, cmd, channel, level, immediate, output ready);
endinterface

interface mcpf_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [mcpf_pkg::LED_W-1:0]  led_on;

	modport source (output valid, led_on, input ready);
	modport sink (input valid, led_on, output ready);
endinterface

@@ src/mcpf_regs.sv @@
module mcpf_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mcpf_pkg::ADDR_W-1:0]        paddr,
	input  logic [mcpf_pkg::DATA_W-1:0]        pwdata,
	output logic [mcpf_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	output logic [mcpf_pkg::RAMP_W-1:0]        ramp_interval
);

	logic [mcpf_pkg::RAMP_W-1:0] ramp_q;
	logic                        sel_ramp;

	assign pready        = 1'b1;
	assign sel_ramp      = (paddr[mcpf_pkg::ADDR_W-1] == mcpf_pkg::REG_RAMP);
	assign ramp_interval = ramp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q <= mcpf_pkg::RAMP_RESET;
		end else if (psel && penable && pwrite && pready && sel_ramp) begin
			ramp_q <= pwdata[mcpf_pkg::RAMP_W-1:0];
		end
	end

	always_comb begin
		if (sel_ramp) begin
			prdata = mcpf_pkg::DATA_W'(ramp_q);
		end else begin
			prdata = '0;
		end
	end

endmodule

@@ src/mcpf_ctrl.sv @@
`include "assert_macros.svh"

module mcpf_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         cmd,
	input  logic [mcpf_pkg::CH_W-1:0]    channel,
	input  logic [mcpf_pkg::LVL_W-1:0]   level,
	input  logic                         immediate,
	input  logic [mcpf_pkg::RAMP_W-1:0]  ramp_interval,
	output mcpf_pkg::item_t              item
);

	logic [mcpf_pkg::LVL_W-1:0]  phase_q;
	logic [mcpf_pkg::RAMP_W-1:0] cnt_q;
	logic [mcpf_pkg::LVL_W-1:0]  phase_nx;
	logic [mcpf_pkg::RAMP_W-1:0] cnt_dec;
	logic [mcpf_pkg::LVL_W-1:0]  lvl_sat;
	logic                        ramp;
	logic                        tick_acc;

	assign tick_acc = accept && (cmd == mcpf_pkg::CMD_TICK);
	assign cnt_dec  = cnt_q - mcpf_pkg::RAMP_W'(1);
	assign ramp     = (cnt_dec == '0);

	always_comb begin
		if (phase_q >= mcpf_pkg::LVL_W'(mcpf_pkg::PWM_TOP)) begin
			phase_nx = '0;
		end else begin
			phase_nx = phase_q + mcpf_pkg::LVL_W'(1);
		end
		if (level > mcpf_pkg::LVL_W'(mcpf_pkg::PWM_TOP)) begin
			lvl_sat = mcpf_pkg::LVL_W'(mcpf_pkg::PWM_TOP);
		end else begin
			lvl_sat = level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mcpf_pkg::LVL_W'(mcpf_pkg::PWM_TOP);
			cnt_q   <= mcpf_pkg::RAMP_RESET;
		end else if (tick_acc) begin
			phase_q <= phase_nx;
			cnt_q   <= ramp ? ramp_interval : cnt_dec;
		end
	end

	always_comb begin
		item.cmd       = cmd;
		item.channel   = channel;
		item.level     = lvl_sat;
		item.immediate = immediate;
		item.phase     = phase_nx;
		item.ramp      = ramp;
	end

	`ASSERT_IMP(a_phase_range, 1'b1, phase_q <= mcpf_pkg::LVL_W'(mcpf_pkg::PWM_TOP))
	`ASSERT_NEXT(a_reload, tick_acc && (cnt_q == mcpf_pkg::RAMP_W'(1)), cnt_q == $past(ramp_interval))

endmodule

@@ src/mcpf_cell.sv @@
`include "assert_macros.svh"

module mcpf_cell #(
	parameter int NUM_CHANNELS = mcpf_pkg::NUM_CHANNELS_DEF,
	parameter int IDX          = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     up_valid,
	input  mcpf_pkg::item_t          up_item,
	input  logic [NUM_CHANNELS-1:0]  up_bits,
	output logic                     up_ready,
	output logic                     dn_valid,
	output mcpf_pkg::item_t          dn_item,
	output logic [NUM_CHANNELS-1:0]  dn_bits,
	input  logic                     dn_ready
);

	logic                        v_q;
	mcpf_pkg::item_t             item_q;
	logic [NUM_CHANNELS-1:0]     bits_q;
	logic [NUM_CHANNELS-1:0]     bits_nx;
	logic [mcpf_pkg::LVL_W-1:0]  tgt_q;
	logic [mcpf_pkg::LVL_W-1:0]  cur_q;
	logic                        ld;
	logic                        hit;

	assign up_ready = !v_q || dn_ready;
	assign ld       = up_valid && up_ready;
	assign hit      = (up_item.cmd == mcpf_pkg::CMD_SET) &&
	                  (up_item.channel == mcpf_pkg::CH_W'(IDX));
	assign dn_valid = v_q;
	assign dn_item  = item_q;
	assign dn_bits  = bits_q;

	always_comb begin
		bits_nx      = up_bits;
		bits_nx[IDX] = (up_item.phase < cur_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			item_q <= up_item;
			bits_q <= bits_nx;
		end
	end

	// channel levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q <= '0;
			cur_q <= '0;
		end else if (ld) begin
			if (hit) begin
				tgt_q <= up_item.level;
				if (up_item.immediate) begin
					cur_q <= up_item.level;
				end
			end else if ((up_item.cmd == mcpf_pkg::CMD_TICK) && up_item.ramp) begin
				if (tgt_q > cur_q) begin
					cur_q <= cur_q + mcpf_pkg::LVL_W'(1);
				end else if (tgt_q < cur_q) begin
					cur_q <= cur_q - mcpf_pkg::LVL_W'(1);
				end
			end
		end
	end

	`ASSERT_IMP(a_cur_range, 1'b1, cur_q <= mcpf_pkg::LVL_W'(mcpf_pkg::PWM_TOP))
	`ASSERT_NEXT(a_hold, v_q && !dn_ready, v_q && $stable(item_q) && $stable(bits_q))

endmodule

@@ src/multi_channel_pwm_fader_core.sv @@
// multi-channel pwm led fader
// req channel: one word per command. cmd tick advances the pwm phase
// (0..10) and the ramp countdown and yields one led_on word on rsp; cmd set
// writes a channel's target level (saturated to 10) and, with immediate,
// its current level, and yields nothing. set words for channels at or
// above NUM_CHANNELS are dropped.
// each channel is a cell in a row; while rsp does not stall, a word walks
// the row one cell per cycle, every cell applying it to its own levels and
// filling its led_on bit. throughput: one word per cycle while rsp does not
// stall. a tick accepted on req passes each cell register in turn, then the
// output register, and is presented on rsp; results leave in the order the
// ticks were taken. if rsp stalls the row keeps filling until every cell
// holds a word, then req.ready drops; nothing is lost or repeated.
// ramp_interval sits at apb address 0 and is reloaded into the countdown
// when it expires. reset clears all levels, sets the phase to 10 and the
// countdown and ramp_interval to 25; no clearing pass is needed.
module multi_channel_pwm_fader_core #(
	parameter int NUM_CHANNELS = mcpf_pkg::NUM_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mcpf_pkg::ADDR_W-1:0]   paddr,
	input  logic [mcpf_pkg::DATA_W-1:0]   pwdata,
	output logic [mcpf_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	mcpf_req_if.sink                      req,
	mcpf_rsp_if.source                    rsp
);

	logic [mcpf_pkg::RAMP_W-1:0]  ramp_interval;
	mcpf_pkg::item_t              item0;
	logic                         v    [0:NUM_CHANNELS];
	logic                         rdy  [0:NUM_CHANNELS];
	mcpf_pkg::item_t              itm  [0:NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]      bits [0:NUM_CHANNELS];
	logic                         out_valid_q;
	logic [mcpf_pkg::LED_W-1:0]   led_q;

	mcpf_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.ramp_interval (ramp_interval)
	);

	mcpf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (req.valid && req.ready),
		.cmd           (req.cmd),
		.channel       (req.channel),
		.level         (req.level),
		.immediate     (req.immediate),
		.ramp_interval (ramp_interval),
		.item          (item0)
	);

	assign v[0]      = req.valid;
	assign itm[0]    = item0;
	assign bits[0]   = '0;
	assign req.ready = rdy[0];

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
		mcpf_cell #(
			.NUM_CHANNELS (NUM_CHANNELS),
			.IDX          (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (v[i]),
			.up_item  (itm[i]),
			.up_bits  (bits[i]),
			.up_ready (rdy[i]),
			.dn_valid (v[i+1]),
			.dn_item  (itm[i+1]),
			.dn_bits  (bits[i+1]),
			.dn_ready (rdy[i+1])
		);
	end

	assign rdy[NUM_CHANNELS] = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy[NUM_CHANNELS]) begin
			out_valid_q <= v[NUM_CHANNELS] &&
			               (itm[NUM_CHANNELS].cmd == mcpf_pkg::CMD_TICK);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NUM_CHANNELS] && v[NUM_CHANNELS]) begin
			led_q <= mcpf_pkg::LED_W'(bits[NUM_CHANNELS]);
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.led_on = led_q;

endmodule
